[rtl/core/esfca_pkg.sv]
package esfca_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_HIGH = 3'd0,
        REG_TEMP_LOW  = 3'd1,
        REG_HUM_HIGH  = 3'd2,
        REG_HUM_LOW   = 3'd3,
        REG_VOC_HIGH  = 3'd4,
        REG_CO2_HIGH  = 3'd5
    } cfg_reg_t;

    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;
    localparam logic [15:0] RAW_MASK = 16'hFFFC;

    // hundredths: value = offset + floor(scale * raw / 65536)
    localparam logic [30:0]        TEMP_SCALE  = 31'd17572;
    localparam logic signed [15:0] TEMP_OFFSET = -16'sd4685;
    localparam logic [29:0]        HUM_SCALE   = 30'd12500;
    localparam logic signed [15:0] HUM_OFFSET  = -16'sd600;

    localparam logic signed [14:0] TEMP_MIN = -15'sd4685;
    localparam logic signed [14:0] TEMP_MAX = 15'sd12886;
    localparam logic [13:0]        HUM_MAX  = 14'd10000;

    localparam logic signed [14:0] TEMP_HIGH_RST = 15'sd3500;
    localparam logic signed [14:0] TEMP_LOW_RST  = 15'sd500;
    localparam logic [13:0]        HUM_HIGH_RST  = 14'd8500;
    localparam logic [13:0]        HUM_LOW_RST   = 14'd2000;
    localparam logic [15:0]        VOC_HIGH_RST  = 16'd500;
    localparam logic [15:0]        CO2_HIGH_RST  = 16'd1000;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // high byte first
    function automatic logic word_ok(input logic [15:0] word, input logic [7:0] check);
        logic [7:0] c;
        c = crc8_byte(CRC_INIT, word[15:8]);
        c = crc8_byte(c, word[7:0]);
        return c == check;
    endfunction

endpackage

[rtl/core/env_sensor_frame_check_alarm.sv]
// Registers from input accept to result valid: input reg, convert reg, result reg.
// Throughput: one item per cycle; the three-stage pipeline stalls only on m_ready.
// CRC check and the fixed-point multiply sit in stage 2, extremes and alarms in stage 3.
// Reset (aresetn low, synchronous): pipeline empty, limits to defaults,
// stored values and extremes to their initial values.
module env_sensor_frame_check_alarm import esfca_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_temp_word,
    input  logic [7:0]            s_temp_check,
    input  logic [15:0]           s_hum_word,
    input  logic [7:0]            s_hum_check,
    input  logic [15:0]           s_co2_word,
    input  logic [7:0]            s_co2_check,
    input  logic [15:0]           s_voc_word,
    input  logic [7:0]            s_voc_check,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [14:0]    m_temperature,
    output logic [13:0]           m_humidity,
    output logic [15:0]           m_voc_now,
    output logic [15:0]           m_co2_now,
    output logic [5:0]            m_alarm_bits,
    output logic [1:0]            m_status,
    output logic signed [14:0]    m_temp_peak,
    output logic signed [14:0]    m_temp_floor,
    output logic [13:0]           m_hum_peak,
    output logic [13:0]           m_hum_floor,
    output logic [15:0]           m_voc_peak,
    output logic [15:0]           m_co2_peak
);

    // limits
    logic signed [14:0] temp_high_reg, temp_low_reg;
    logic [13:0]        hum_high_reg, hum_low_reg;
    logic [15:0]        voc_high_reg, co2_high_reg;

    // pipeline control
    logic v1_reg, v2_reg, vo_reg;
    logic adv1, adv2, adv_o;

    // stage 1: raw item
    logic [15:0] s1_temp_word_reg, s1_hum_word_reg, s1_co2_word_reg, s1_voc_word_reg;
    logic [7:0]  s1_temp_check_reg, s1_hum_check_reg, s1_co2_check_reg, s1_voc_check_reg;

    // stage 2: checked and converted
    logic               s2_clim_ok_reg, s2_gas_ok_reg;
    logic signed [14:0] s2_temp_reg;
    logic [13:0]        s2_hum_reg;
    logic [15:0]        s2_co2_reg, s2_voc_reg;

    // stage 3: stored state doubles as the result register
    logic signed [14:0] cur_temp_reg, max_temp_reg, min_temp_reg;
    logic [13:0]        cur_hum_reg, max_hum_reg, min_hum_reg;
    logic [15:0]        cur_voc_reg, cur_co2_reg, max_voc_reg, max_co2_reg;
    logic [5:0]         alarm_reg;
    logic [1:0]         status_reg;

    logic signed [14:0] cur_temp_next, max_temp_next, min_temp_next;
    logic [13:0]        cur_hum_next, max_hum_next, min_hum_next;
    logic [15:0]        cur_voc_next, cur_co2_next, max_voc_next, max_co2_next;
    logic [5:0]         alarm_next;

    logic               clim_ok, gas_ok;
    logic [15:0]        raw_t, raw_h;
    logic [30:0]        prod_t;
    logic [29:0]        prod_h;
    logic signed [15:0] t_wide, h_wide;
    logic signed [14:0] temp_conv;
    logic [13:0]        hum_conv;

    assign adv_o   = v2_reg && (!vo_reg || m_ready);
    assign adv2    = v1_reg && (!v2_reg || adv_o);
    assign s_ready = !v1_reg || adv2;
    assign adv1    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (!v2_reg || adv_o) begin
                v2_reg <= v1_reg;
            end
            if (!vo_reg || m_ready) begin
                vo_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_high_reg <= TEMP_HIGH_RST;
            temp_low_reg  <= TEMP_LOW_RST;
            hum_high_reg  <= HUM_HIGH_RST;
            hum_low_reg   <= HUM_LOW_RST;
            voc_high_reg  <= VOC_HIGH_RST;
            co2_high_reg  <= CO2_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_TEMP_HIGH: temp_high_reg <= $signed(cfg_data[14:0]);
                REG_TEMP_LOW:  temp_low_reg  <= $signed(cfg_data[14:0]);
                REG_HUM_HIGH:  hum_high_reg  <= cfg_data[13:0];
                REG_HUM_LOW:   hum_low_reg   <= cfg_data[13:0];
                REG_VOC_HIGH:  voc_high_reg  <= cfg_data;
                REG_CO2_HIGH:  co2_high_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_temp_word_reg  <= s_temp_word;
            s1_temp_check_reg <= s_temp_check;
            s1_hum_word_reg   <= s_hum_word;
            s1_hum_check_reg  <= s_hum_check;
            s1_co2_word_reg   <= s_co2_word;
            s1_co2_check_reg  <= s_co2_check;
            s1_voc_word_reg   <= s_voc_word;
            s1_voc_check_reg  <= s_voc_check;
        end
    end

    always_comb begin
        clim_ok = word_ok(s1_temp_word_reg, s1_temp_check_reg)
                  && word_ok(s1_hum_word_reg, s1_hum_check_reg);
        gas_ok  = word_ok(s1_co2_word_reg, s1_co2_check_reg)
                  && word_ok(s1_voc_word_reg, s1_voc_check_reg);

        raw_t  = s1_temp_word_reg & RAW_MASK;
        raw_h  = s1_hum_word_reg & RAW_MASK;
        prod_t = {15'd0, raw_t} * TEMP_SCALE;
        prod_h = {14'd0, raw_h} * HUM_SCALE;

        t_wide    = TEMP_OFFSET + $signed({1'b0, prod_t[30:16]});
        temp_conv = t_wide[14:0];

        h_wide = HUM_OFFSET + $signed({2'b00, prod_h[29:16]});
        if (h_wide < 0) begin
            hum_conv = '0;
        end else if (h_wide > $signed({2'b00, HUM_MAX})) begin
            hum_conv = HUM_MAX;
        end else begin
            hum_conv = h_wide[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_clim_ok_reg <= clim_ok;
            s2_gas_ok_reg  <= gas_ok;
            s2_temp_reg    <= temp_conv;
            s2_hum_reg     <= hum_conv;
            s2_co2_reg     <= s1_co2_word_reg;
            s2_voc_reg     <= s1_voc_word_reg;
        end
    end

    always_comb begin
        cur_temp_next = cur_temp_reg;
        cur_hum_next  = cur_hum_reg;
        max_temp_next = max_temp_reg;
        min_temp_next = min_temp_reg;
        max_hum_next  = max_hum_reg;
        min_hum_next  = min_hum_reg;
        cur_voc_next  = cur_voc_reg;
        cur_co2_next  = cur_co2_reg;
        max_voc_next  = max_voc_reg;
        max_co2_next  = max_co2_reg;

        if (s2_clim_ok_reg) begin
            cur_temp_next = s2_temp_reg;
            cur_hum_next  = s2_hum_reg;
            if (s2_temp_reg > max_temp_reg) max_temp_next = s2_temp_reg;
            if (s2_temp_reg < min_temp_reg) min_temp_next = s2_temp_reg;
            if (s2_hum_reg > max_hum_reg)   max_hum_next  = s2_hum_reg;
            if (s2_hum_reg < min_hum_reg)   min_hum_next  = s2_hum_reg;
        end
        if (s2_gas_ok_reg) begin
            cur_co2_next = s2_co2_reg;
            cur_voc_next = s2_voc_reg;
            if (s2_voc_reg > max_voc_reg) max_voc_next = s2_voc_reg;
            if (s2_co2_reg > max_co2_reg) max_co2_next = s2_co2_reg;
        end

        // alarms always follow the stored values, good frame or not
        alarm_next[0] = cur_temp_next > temp_high_reg;
        alarm_next[1] = cur_temp_next < temp_low_reg;
        alarm_next[2] = cur_hum_next > hum_high_reg;
        alarm_next[3] = cur_hum_next < hum_low_reg;
        alarm_next[4] = cur_voc_next > voc_high_reg;
        alarm_next[5] = cur_co2_next > co2_high_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_temp_reg <= '0;
            cur_hum_reg  <= '0;
            cur_voc_reg  <= '0;
            cur_co2_reg  <= '0;
            max_temp_reg <= TEMP_MIN;
            min_temp_reg <= TEMP_MAX;
            max_hum_reg  <= '0;
            min_hum_reg  <= HUM_MAX;
            max_voc_reg  <= '0;
            max_co2_reg  <= '0;
        end else if (adv_o) begin
            cur_temp_reg <= cur_temp_next;
            cur_hum_reg  <= cur_hum_next;
            cur_voc_reg  <= cur_voc_next;
            cur_co2_reg  <= cur_co2_next;
            max_temp_reg <= max_temp_next;
            min_temp_reg <= min_temp_next;
            max_hum_reg  <= max_hum_next;
            min_hum_reg  <= min_hum_next;
            max_voc_reg  <= max_voc_next;
            max_co2_reg  <= max_co2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_o) begin
            alarm_reg  <= alarm_next;
            status_reg <= {!s2_gas_ok_reg, !s2_clim_ok_reg};
        end
    end

    assign m_valid       = vo_reg;
    assign m_temperature = cur_temp_reg;
    assign m_humidity    = cur_hum_reg;
    assign m_voc_now     = cur_voc_reg;
    assign m_co2_now     = cur_co2_reg;
    assign m_alarm_bits  = alarm_reg;
    assign m_status      = status_reg;
    assign m_temp_peak   = max_temp_reg;
    assign m_temp_floor  = min_temp_reg;
    assign m_hum_peak    = max_hum_reg;
    assign m_hum_floor   = min_hum_reg;
    assign m_voc_peak    = max_voc_reg;
    assign m_co2_peak    = max_co2_reg;

`ifndef SYNTHESIS
    a_temp_peak_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (max_temp_reg >= $past(max_temp_reg)))
        else $error("temperature peak decreased");

    a_hum_floor_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (min_hum_reg <= $past(min_hum_reg)))
        else $error("humidity floor increased");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_hum_reg <= HUM_MAX)
        else $error("stored humidity above full scale");

    a_bad_clim_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv_o && !s2_clim_ok_reg) |=> ($stable(cur_temp_reg) && $stable(cur_hum_reg)))
        else $error("climate values changed on a bad CRC");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (vo_reg && !m_ready && v2_reg && v1_reg) |-> !s_ready)
        else $error("input taken while pipeline is full and stalled");
`endif

endmodule
